// ===== hw/rtl/pdds_pkg.sv =====
// shared types, constants and build-time tables for the polyphonic dds sine mixer
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package pdds_pkg;

    localparam int MAX_NOTES      = 8;
    localparam int SAMPLE_BITS    = 16;
    localparam int PHASE_WIDTH    = 32;
    localparam int SAMPLE_RATE_HZ = 20000;
    localparam int SINE_ENTRIES   = 256;

    localparam int FUNC_W      = 2;
    localparam int OCT_W       = 5;
    localparam int SEMI_W      = 4;
    localparam int OUT_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;
    localparam int CODE_W      = 7;
    localparam int NUM_CODES   = 128;
    localparam int CODE_FULL_W = 9;
    localparam int ROM_AW      = 8;
    localparam int QTR         = SINE_ENTRIES / 4;

    localparam int SLOT_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W  = $clog2(MAX_NOTES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DIVC_W = $clog2(SUM_W + 1);

    localparam logic [CFG_W-1:0] MIX_OFFSET_RST = 16'd32767;
    localparam logic [CFG_W-1:0] SILENCE_RST    = 16'd32767;

    localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MIX_LO = -MIX_HI - SUM_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK     = 2'd0,
        FN_NOTE_ON  = 2'd1,
        FN_NOTE_OFF = 2'd2,
        FN_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_NO_NOTES = 2'd2,
        ST_BAD_CODE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_MIX_OFFSET = 1'b0,
        REG_SILENCE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] mix_offset;
        logic [CFG_W-1:0] silence_value;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] sample;
        status_t          status;
    } res_t;

    typedef logic signed [SAMPLE_BITS-1:0] sine_tab_t [SINE_ENTRIES];
    typedef logic [PHASE_WIDTH-1:0] step_tab_t [NUM_CODES];

    // sine series in q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned SERIES_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // round(1e9 * 2^(s/12))
    localparam longint unsigned SEMI_RATIO [12] = '{
        64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
        64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
        64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
    };
    localparam longint unsigned STEP_DEN = 64'(SAMPLE_RATE_HZ) * 64'd1000000000;

    function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input int unsigned k);
        longint unsigned amp;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        x    = (PI_Q30 * 64'(k)) >> 7;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / SERIES_DIV[n-1];
            if ((n & 1) == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        v = (amp * longint'(acc) + (64'd1 << 20)) >> 30;
        if (v > amp)
        begin
            v = amp;
        end
        return SAMPLE_BITS'(v);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            if (i <= QTR)
            begin
                tab[i] = quarter_sine(i);
            end
            else if (i <= 2 * QTR)
            begin
                tab[i] = quarter_sine(2 * QTR - i);
            end
            else if (i <= 3 * QTR)
            begin
                tab[i] = SAMPLE_BITS'(-quarter_sine(i - 2 * QTR));
            end
            else
            begin
                tab[i] = SAMPLE_BITS'(-quarter_sine(SINE_ENTRIES - i));
            end
        end
        return tab;
    endfunction

    function automatic step_tab_t build_step_tab();
        step_tab_t       tab;
        int              t;
        int              e;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        for (int code = 0; code < NUM_CODES; code++)
        begin
            t   = code + 3;
            e   = PHASE_WIDTH + (t / 12) - 6;
            num = 64'd440 * SEMI_RATIO[t % 12];
            q   = num / STEP_DEN;
            r   = num % STEP_DEN;
            for (int i = 0; i < e; i++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= STEP_DEN)
                begin
                    q = q | 64'd1;
                    r = r - STEP_DEN;
                end
            end
            if ((2 * r) >= STEP_DEN)
            begin
                q = q + 64'd1;
            end
            tab[code] = PHASE_WIDTH'(q);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_ROM = build_sine_tab();
    localparam step_tab_t STEP_ROM = build_step_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/pdds_if.sv =====
// valid/ready channel interfaces for note and tick words in and sample words out
// depends on pdds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pdds_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [pdds_pkg::FUNC_W-1:0]          func;
    logic signed [pdds_pkg::OCT_W-1:0]    octave;
    logic [pdds_pkg::SEMI_W-1:0]          semitone;

    modport source (output valid, output func, output octave, output semitone, input ready);
    modport sink (input valid, input func, input octave, input semitone, output ready);
endinterface

interface pdds_out_if;
    logic                            valid;
    logic                            ready;
    logic [pdds_pkg::OUT_W-1:0]      sample_out;
    logic [pdds_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output sample_out, output status, input ready);
    modport sink (input valid, input sample_out, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pdds_apb.sv =====
// apb register file holding the mix offset and silence_value
// depends on pdds_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdds_apb (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdds_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [pdds_pkg::APB_DW-1:0]     pwdata,
    output logic      [pdds_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    output pdds_pkg::cfg_t                       cfg
);

    logic [pdds_pkg::CFG_W-1:0] mix_offset_reg;
    logic [pdds_pkg::CFG_W-1:0] mix_offset_next;
    logic [pdds_pkg::CFG_W-1:0] silence_reg;
    logic [pdds_pkg::CFG_W-1:0] silence_next;
    logic                       wr_en;
    pdds_pkg::reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = pdds_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        mix_offset_next = mix_offset_reg;
        silence_next    = silence_reg;
        if (wr_en)
        begin
            case (idx)
                pdds_pkg::REG_MIX_OFFSET: mix_offset_next = pwdata[pdds_pkg::CFG_W-1:0];
                pdds_pkg::REG_SILENCE:    silence_next    = pwdata[pdds_pkg::CFG_W-1:0];
                default:                  mix_offset_next = mix_offset_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pdds_pkg::REG_MIX_OFFSET: prdata = pdds_pkg::APB_DW'(mix_offset_reg);
            pdds_pkg::REG_SILENCE:    prdata = pdds_pkg::APB_DW'(silence_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_offset_reg <= pdds_pkg::MIX_OFFSET_RST;
            silence_reg    <= pdds_pkg::SILENCE_RST;
        end
        else
        begin
            mix_offset_reg <= mix_offset_next;
            silence_reg    <= silence_next;
        end
    end

    assign cfg.mix_offset    = mix_offset_reg;
    assign cfg.silence_value = silence_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pdds_div.sv =====
// one bit per cycle signed divider of the mixed sum by the active note count
// depends on pdds_pkg; quotient truncates toward zero
`timescale 1ns / 1ps
`default_nettype none

module pdds_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  pdds_pkg::div_req_t       req,
    output pdds_pkg::div_rsp_t       rsp
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [pdds_pkg::DIVC_W-1:0]       cnt_reg;
    logic [pdds_pkg::DIVC_W-1:0]       cnt_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic [pdds_pkg::SUM_W-1:0]        quo_reg;
    logic [pdds_pkg::SUM_W-1:0]        quo_next;
    logic [pdds_pkg::CNT_W-1:0]        rem_reg;
    logic [pdds_pkg::CNT_W-1:0]        rem_next;
    logic [pdds_pkg::CNT_W-1:0]        dvs_reg;
    logic [pdds_pkg::CNT_W-1:0]        dvs_next;
    logic [pdds_pkg::CNT_W:0]          trial;
    logic [pdds_pkg::CNT_W:0]          diff;
    logic                              ge;
    logic [pdds_pkg::SUM_W-1:0]        mag;

    assign mag   = req.dividend[pdds_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign trial = {rem_reg, quo_reg[pdds_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = pdds_pkg::DIVC_W'(pdds_pkg::SUM_W);
            neg_next  = req.dividend[pdds_pkg::SUM_W-1];
            quo_next  = mag;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[pdds_pkg::CNT_W-1:0] : trial[pdds_pkg::CNT_W-1:0];
            quo_next = {quo_reg[pdds_pkg::SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pdds_pkg::DIVC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pdds_ctrl.sv =====
// sequencer and note slot state: walks the slots one per cycle for ticks and note events
// depends on pdds_pkg, pdds_if and the pdds_div response
`timescale 1ns / 1ps
`default_nettype none

module pdds_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    pdds_in_if.sink              in_ch,
    input  pdds_pkg::cfg_t       cfg,
    output pdds_pkg::div_req_t   div_req,
    input  pdds_pkg::div_rsp_t   div_rsp,
    output pdds_pkg::res_t       res,
    input  wire logic            res_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    localparam int NOTES = pdds_pkg::MAX_NOTES;
    localparam int PW    = pdds_pkg::PHASE_WIDTH;
    localparam int SB    = pdds_pkg::SAMPLE_BITS;
    localparam int SW    = pdds_pkg::SUM_W;
    localparam int CW    = pdds_pkg::CNT_W;
    localparam int FW    = pdds_pkg::CODE_FULL_W;
    localparam int XW    = pdds_pkg::SLOT_W;

    state_t                              state_reg;
    state_t                              state_next;
    pdds_pkg::func_t                     func_reg;
    pdds_pkg::func_t                     func_next;
    logic [pdds_pkg::CODE_W-1:0]         code_reg;
    logic [pdds_pkg::CODE_W-1:0]         code_next;
    logic [XW-1:0]                       idx_reg;
    logic [XW-1:0]                       idx_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic signed [SW-1:0]                sum_reg;
    logic signed [SW-1:0]                sum_next;
    logic [pdds_pkg::OUT_W-1:0]          sample_reg;
    logic [pdds_pkg::OUT_W-1:0]          sample_next;
    pdds_pkg::status_t                   status_reg;
    pdds_pkg::status_t                   status_next;
    logic                                div_start_reg;
    logic                                div_start_next;

    logic [PW-1:0]                       accum_reg [NOTES];
    logic [PW-1:0]                       step_reg [NOTES];
    logic [pdds_pkg::CODE_W-1:0]         slot_code_reg [NOTES];
    logic [NOTES-1:0]                    active_reg;

    logic                                acc_we;
    logic                                on_we;
    logic                                off_we;
    logic [pdds_pkg::SLOT_W-1:0]         slot;
    logic                                last;
    logic [PW-1:0]                       phase_sum;
    logic signed [SB-1:0]                sine_val;
    logic signed [SW-1:0]                sum_add;
    logic signed [FW-1:0]                oct_ext;
    logic signed [FW-1:0]                code_full;
    logic                                code_bad;
    logic signed [SW-1:0]                quo;
    logic signed [SB-1:0]                mixed;
    logic [pdds_pkg::OUT_W-1:0]          mix_sample;

    // note code decode
    assign oct_ext   = FW'(in_ch.octave) + FW'(2);
    assign code_full = (oct_ext <<< 3) + (oct_ext <<< 2) + $signed(FW'(in_ch.semitone));
    assign code_bad  = (code_full < FW'(0)) ||
                       (code_full > $signed(FW'(pdds_pkg::NUM_CODES - 1)));

    // per-slot datapath
    assign slot      = idx_reg;
    assign last      = idx_reg == XW'(NOTES - 1);
    assign phase_sum = accum_reg[slot] + step_reg[slot];
    assign sine_val  = pdds_pkg::SINE_ROM[phase_sum[PW-1 -: pdds_pkg::ROM_AW]];
    assign sum_add   = sum_reg + SW'(sine_val);

    // mix scaling
    assign quo = $signed(div_rsp.quotient);
    always_comb
    begin
        if (quo > pdds_pkg::MIX_HI)
        begin
            mixed = SB'(pdds_pkg::MIX_HI);
        end
        else if (quo < pdds_pkg::MIX_LO)
        begin
            mixed = SB'(pdds_pkg::MIX_LO);
        end
        else
        begin
            mixed = SB'(quo);
        end
    end
    assign mix_sample = pdds_pkg::OUT_W'(mixed) + cfg.mix_offset;

    assign in_ch.ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        status_next    = status_reg;
        div_start_next = 1'b0;
        acc_we         = 1'b0;
        on_we          = 1'b0;
        off_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    func_next   = pdds_pkg::func_t'(in_ch.func);
                    code_next   = code_full[pdds_pkg::CODE_W-1:0];
                    idx_next    = '0;
                    sum_next    = '0;
                    sample_next = '0;
                    status_next = pdds_pkg::ST_OK;
                    state_next  = S_FIN;
                    case (pdds_pkg::func_t'(in_ch.func))
                        pdds_pkg::FN_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                sample_next = cfg.silence_value;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        pdds_pkg::FN_NOTE_ON:
                        begin
                            if (count_reg >= CW'(NOTES))
                            begin
                                status_next = pdds_pkg::ST_NO_SLOT;
                            end
                            else if (code_bad)
                            begin
                                status_next = pdds_pkg::ST_BAD_CODE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        pdds_pkg::FN_NOTE_OFF:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = pdds_pkg::ST_NO_NOTES;
                            end
                            else if (code_bad)
                            begin
                                status_next = pdds_pkg::ST_BAD_CODE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                case (func_reg)
                    pdds_pkg::FN_TICK:
                    begin
                        if (active_reg[slot])
                        begin
                            acc_we   = 1'b1;
                            sum_next = sum_add;
                        end
                        if (last)
                        begin
                            div_start_next = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                    pdds_pkg::FN_NOTE_ON:
                    begin
                        if (!active_reg[slot])
                        begin
                            on_we      = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = S_FIN;
                        end
                        else if (last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    pdds_pkg::FN_NOTE_OFF:
                    begin
                        if (active_reg[slot] && (slot_code_reg[slot] == code_reg))
                        begin
                            off_we     = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = S_FIN;
                        end
                        else if (last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    sample_next = mix_sample;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            div_start_reg <= 1'b0;
            active_reg    <= '0;
            for (int i = 0; i < NOTES; i++)
            begin
                accum_reg[i]     <= '0;
                step_reg[i]      <= '0;
                slot_code_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            div_start_reg <= div_start_next;
            if (acc_we)
            begin
                accum_reg[slot] <= phase_sum;
            end
            if (on_we)
            begin
                slot_code_reg[slot] <= code_reg;
                step_reg[slot]      <= pdds_pkg::STEP_ROM[code_reg];
                active_reg[slot]    <= 1'b1;
            end
            if (off_we)
            begin
                active_reg[slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        code_reg   <= code_next;
        sum_reg    <= sum_next;
        sample_reg <= sample_next;
        status_reg <= status_next;
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = count_reg;

    assign res.valid  = state_reg == S_FIN;
    assign res.sample = sample_reg;
    assign res.status = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/polyphonic_dds_sine_mixer_core.sv =====
// a tick word with notes sounding walks the slots one per cycle through the shared phase
// adder and sine rom, then takes one quotient bit per cycle from the divider; its result
// word is registered at the output as the block returns to idle
// note-on/off words walk slots up to a free or matching one; silent ticks and rejects skip it
// throughput: one word at a time; the next word is taken while a result waits
// reset: rst_n asynchronous active low, clears all slots, the count and the control registers
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_dds_sine_mixer_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pdds_in_if.sink                              in_ch,
    pdds_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdds_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [pdds_pkg::APB_DW-1:0]     pwdata,
    output logic      [pdds_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);

    pdds_pkg::cfg_t                 cfg;
    pdds_pkg::div_req_t             div_req;
    pdds_pkg::div_rsp_t             div_rsp;
    pdds_pkg::res_t                 res;
    logic                           res_ready;
    logic                           load;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [pdds_pkg::OUT_W-1:0]     out_sample_reg;
    logic [pdds_pkg::OUT_W-1:0]     out_sample_next;
    pdds_pkg::status_t              out_status_reg;
    pdds_pkg::status_t              out_status_next;

    pdds_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pdds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res       (res),
        .res_ready (res_ready)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ch.ready;
    assign load      = res.valid && res_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_status_next = out_status_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = res.sample;
            out_status_next = res.status;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_status_reg <= out_status_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.status     = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pdds_checker.sv =====
// port-level checks for the dds mixer core, attached by bind
// depends on pdds_pkg and polyphonic_dds_sine_mixer_core
`timescale 1ns / 1ps
`default_nettype none

module pdds_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [pdds_pkg::OUT_W-1:0]      out_sample,
    input wire logic [pdds_pkg::STATUS_W-1:0]   out_status
);

    // busy once a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready stayed high after a word was taken");

    // returning to idle always hands a result word to the output
    a_idle_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("block went idle without a result word");

    // error status only on note events, which carry a zero sample
    a_error_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status != pdds_pkg::ST_OK)) |-> (out_sample == '0))
        else $error("error status with nonzero sample");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_sample) && $stable(out_status)))
        else $error("stalled output word changed");

endmodule

bind polyphonic_dds_sine_mixer_core pdds_checker u_pdds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out),
    .out_status (out_ch.status)
);

`default_nettype wire
